### design/fp32_multiplier_assert.svh
// Assertion macros for the fp32 multiplier pipeline.
// Used by fp32_multiplier.sv; no other dependencies.
`ifndef FP32_MULTIPLIER_ASSERT_SVH
`define FP32_MULTIPLIER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fm_pkg.sv
// Package for the fp32 multiplier: constants and stage payload types.
// No dependencies.
package fm_pkg;

  localparam logic [31:0] QNAN_POS = 32'h7fc0_0000;
  localparam logic [31:0] QNAN_NEG = 32'hffc0_0000;
  localparam logic [31:0] INF_POS  = 32'h7f80_0000;
  localparam logic [31:0] INF_NEG  = 32'hff80_0000;
  localparam logic [7:0]  EXP_MAX  = 8'hff;
  localparam logic [9:0]  EXP_BIAS = 10'd127;

  // stage 1 -> stage 2
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [31:0] special_val;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [9:0]  exp;   // signed biased exponent before normalization
  } fm_s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [31:0] special_val;
    logic [47:0] prod;
    logic [9:0]  exp;
  } fm_s2_t;

  // stage 3 -> stage 4
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [31:0] special_val;
    logic [23:0] mant;  // rounded significand
    logic [9:0]  exp;
  } fm_s3_t;

endpackage

### design/fp32_multiplier.sv
// Top level of the pipelined binary32 multiplier.
// Depends on fm_pkg and fp32_multiplier_assert.svh.
//
//  channel | ports                             | direction
//  in      | in_valid in_stall in_operand_a/b  | item in
//  out     | out_valid out_stall out_product   | item out
//
// Four register stages: unpack, 24x24 multiply, normalize/round, pack.
// An accepted item passes through s1_r, s2_r, s3_r and prod_r to out_*;
// one item per cycle sustained while out_stall is low.
// A stalled output holds stage 4; earlier stages still move into empty slots,
// so in_stall rises only when all four stages hold an item and out_stall is high.
// Synchronous active-low reset clears the valid bits only.
`include "fp32_multiplier_assert.svh"

module fp32_multiplier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_product
);
  import fm_pkg::*;

  logic   v1_r, v2_r, v3_r, v4_r;
  logic   en1, en2, en3, en4;
  fm_s1_t s1_r, s1_nxt;
  fm_s2_t s2_r, s2_nxt;
  fm_s3_t s3_r, s3_nxt;
  logic [31:0] prod_r, prod_nxt;

  // per-stage advance: a stage may load when it is empty or the stage after it may load
  assign en4 = !v4_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall  = !en1;
  assign out_valid = v4_r;
  assign out_product = prod_r;

  // stage 1: unpack and classify
  always_comb begin
    logic       sa, sb, za, zb, ia, ib, na, nb;
    logic [7:0] ea, eb;
    logic [22:0] fa, fb;
    sa = in_operand_a[31];
    sb = in_operand_b[31];
    ea = in_operand_a[30:23];
    eb = in_operand_b[30:23];
    fa = in_operand_a[22:0];
    fb = in_operand_b[22:0];
    za = (ea == 8'd0) && (fa == 23'd0);
    zb = (eb == 8'd0) && (fb == 23'd0);
    ia = (ea == EXP_MAX) && (fa == 23'd0);
    ib = (eb == EXP_MAX) && (fb == 23'd0);
    na = (ea == EXP_MAX) && (fa != 23'd0);
    nb = (eb == EXP_MAX) && (fb != 23'd0);
    s1_nxt.sign = sa ^ sb;
    s1_nxt.special = na || nb || za || zb || ia || ib;
    if (na || nb) begin
      s1_nxt.special_val = QNAN_NEG;
    end else if ((za && ib) || (ia && zb)) begin
      s1_nxt.special_val = (sa ^ sb) ? QNAN_NEG : QNAN_POS;
    end else if (za || zb) begin
      s1_nxt.special_val = {sa ^ sb, 31'd0};
    end else begin
      s1_nxt.special_val = (sa ^ sb) ? INF_NEG : INF_POS;
    end
    s1_nxt.ma  = {ea != 8'd0, fa};
    s1_nxt.mb  = {eb != 8'd0, fb};
    s1_nxt.exp = {2'b00, (ea != 8'd0) ? ea : 8'd1} + {2'b00, (eb != 8'd0) ? eb : 8'd1}
                 - EXP_BIAS;
  end

  // stage 2: multiply
  always_comb begin
    s2_nxt.sign        = s1_r.sign;
    s2_nxt.special     = s1_r.special;
    s2_nxt.special_val = s1_r.special_val;
    s2_nxt.prod        = {24'd0, s1_r.ma} * {24'd0, s1_r.mb};
    s2_nxt.exp         = s1_r.exp;
  end

  // stage 3: normalize by one and round to nearest even
  always_comb begin
    logic [23:0] m;
    logic [24:0] mr;
    logic        g, r, s;
    logic [9:0]  e;
    e = s2_r.exp;
    if (s2_r.prod[47]) begin
      m = s2_r.prod[47:24];
      g = s2_r.prod[23];
      r = s2_r.prod[22];
      s = |s2_r.prod[21:0];
      e = e + 10'd1;
    end else begin
      m = s2_r.prod[46:23];
      g = s2_r.prod[22];
      r = s2_r.prod[21];
      s = |s2_r.prod[20:0];
    end
    mr = {1'b0, m} + {24'd0, g && (r || s || m[0])};
    if (mr[24]) begin
      m = mr[24:1];
      e = e + 10'd1;
    end else begin
      m = mr[23:0];
    end
    s3_nxt.sign        = s2_r.sign;
    s3_nxt.special     = s2_r.special;
    s3_nxt.special_val = s2_r.special_val;
    s3_nxt.mant        = m;
    s3_nxt.exp         = e;
  end

  // stage 4: overflow, underflow shift, pack
  always_comb begin
    logic [9:0]  sh;
    logic [23:0] m;
    sh = 10'd1 - s3_r.exp;
    m  = s3_r.mant;
    if (s3_r.special) begin
      prod_nxt = s3_r.special_val;
    end else if (!s3_r.exp[9] && (s3_r.exp >= 10'd255)) begin
      prod_nxt = s3_r.sign ? INF_NEG : INF_POS;
    end else if (s3_r.exp[9] || (s3_r.exp == 10'd0)) begin
      if (sh < 10'd24) begin
        m = m >> sh[4:0];
      end else begin
        m = 24'd0;
      end
      prod_nxt = {s3_r.sign, 8'd0, m[22:0]};
    end else begin
      prod_nxt = {s3_r.sign, s3_r.exp[7:0], m[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
    if (en4) prod_r <= prod_nxt;
  end

  `FM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_product),
                 "stalled item changed")
  `FM_ASSERT_IMP(a_stall_full, in_stall, v1_r && v2_r && v3_r && v4_r,
                 "stall with a hole in the pipeline")
  `FM_ASSERT_NXT(a_adv, v3_r && !out_stall, out_valid, "item lost before output")

endmodule
